[src/i2cmrt_pkg.sv]
// i2cmrt_pkg: types and codes shared by the register transaction sequencer
// used by i2cmrt_step and i2c_master_register_transaction_unit; no dependencies
`default_nettype none

package i2cmrt_pkg;

    localparam logic [15:0] MAX_ATTEMPTS_RESET = 16'd1600;

    // action codes
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_EVENT = 2'd2;

    // byte engine status codes
    localparam logic [3:0] ST_START       = 4'd0;
    localparam logic [3:0] ST_REP_START   = 4'd1;
    localparam logic [3:0] ST_MT_SLA_ACK  = 4'd2;
    localparam logic [3:0] ST_MT_SLA_NACK = 4'd3;
    localparam logic [3:0] ST_MT_DATA_ACK = 4'd4;
    localparam logic [3:0] ST_MT_DATA_NAK = 4'd5;
    localparam logic [3:0] ST_ARB_LOST    = 4'd6;
    localparam logic [3:0] ST_MR_SLA_ACK  = 4'd7;
    localparam logic [3:0] ST_MR_SLA_NACK = 4'd8;
    localparam logic [3:0] ST_MR_DATA_ACK = 4'd9;
    localparam logic [3:0] ST_MR_DATA_NAK = 4'd10;

    // configuration register indexes
    localparam logic CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic CFG_MAX_ATTEMPTS  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_SLAW   = 3'd2,
        PH_ADDR   = 3'd3,
        PH_RSTART = 3'd4,
        PH_SLAR   = 3'd5,
        PH_RX     = 3'd6,
        PH_VAL    = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_BYTE  = 3'd2,
        CMD_RXACK = 3'd3,
        CMD_RXNAK = 3'd4,
        CMD_STOP  = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic [7:0] write_value;
        logic [3:0] bus_status;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        t_phase      phase;
        logic        is_read;
        logic [15:0] attempts_used;
        logic [7:0]  bytes_left;
        logic [7:0]  bytes_done;
        logic [7:0]  saved_reg_addr;
        logic [7:0]  saved_value;
    } t_state;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       done;
        logic [7:0] byte_count;
    } t_result;

endpackage

`default_nettype wire

[src/i2cmrt_step.sv]
// i2cmrt_step: next state and result for one input item of the sequencer
// depends on i2cmrt_pkg
`default_nettype none

module i2cmrt_step
    import i2cmrt_pkg::*;
(
    input  var t_state      i_state,
    input  var t_item       i_item,
    input  wire logic [7:0] i_slave_address,
    input  wire logic [15:0] i_max_attempts,
    output t_state          o_state,
    output t_result         o_result
);

    logic       w_give_up;
    logic [7:0] w_sla_w;
    logic [7:0] w_bl_dec;
    logic [7:0] w_bd_inc;
    logic [3:0] w_st;

    assign w_give_up = (i_state.attempts_used >= i_max_attempts);
    assign w_sla_w   = {i_slave_address[7:1], 1'b0};
    assign w_bl_dec  = (i_state.bytes_left != 8'd0) ? i_state.bytes_left - 8'd1 : 8'd0;
    assign w_bd_inc  = i_state.bytes_done + 8'd1;
    assign w_st      = i_item.bus_status;

    always_comb begin
        o_state  = i_state;
        o_result = '{cmd: CMD_NONE, default: '0};

        if (i_item.action == ACT_READ || i_item.action == ACT_WRITE) begin
            if (i_state.phase == PH_IDLE) begin
                o_state.is_read        = (i_item.action == ACT_READ);
                o_state.saved_reg_addr = i_item.reg_addr;
                o_state.bytes_left     = i_item.length;
                o_state.saved_value    = i_item.write_value;
                o_state.bytes_done     = 8'd0;
                o_state.attempts_used  = 16'd0;
                if (i_max_attempts == 16'd0) begin
                    o_result.done = 1'b1;
                end else begin
                    o_state.attempts_used = 16'd1;
                    o_state.phase         = PH_START;
                    o_result.cmd          = CMD_START;
                end
            end
        end else if (i_item.action == ACT_EVENT) begin
            case (i_state.phase)
                PH_START: begin
                    if (w_st == ST_START || w_st == ST_REP_START) begin
                        o_state.phase   = PH_SLAW;
                        o_result.cmd    = CMD_BYTE;
                        o_result.tx_byte = w_sla_w;
                    end else if (w_st == ST_ARB_LOST) begin
                        o_result.cmd = CMD_START;
                    end else begin
                        o_state.phase = PH_IDLE;
                        o_result.done = 1'b1;
                    end
                end
                PH_SLAW: begin
                    if (w_st == ST_MT_SLA_ACK) begin
                        o_state.phase    = PH_ADDR;
                        o_result.cmd     = CMD_BYTE;
                        o_result.tx_byte = i_state.saved_reg_addr;
                    end else if (w_st == ST_MT_SLA_NACK) begin
                        if (w_give_up) begin
                            o_state.phase = PH_IDLE;
                            o_result.done = 1'b1;
                        end else begin
                            o_state.attempts_used = i_state.attempts_used + 16'd1;
                            o_state.phase         = PH_START;
                            o_result.cmd          = CMD_START;
                        end
                    end else if (w_st == ST_ARB_LOST) begin
                        o_state.phase = PH_START;
                        o_result.cmd  = CMD_START;
                    end else begin
                        o_state.phase = PH_IDLE;
                        o_result.cmd  = CMD_STOP;
                        o_result.done = 1'b1;
                    end
                end
                PH_ADDR: begin
                    if (w_st == ST_MT_DATA_ACK) begin
                        if (i_state.is_read) begin
                            o_state.phase = PH_RSTART;
                            o_result.cmd  = CMD_START;
                        end else begin
                            o_state.phase    = PH_VAL;
                            o_result.cmd     = CMD_BYTE;
                            o_result.tx_byte = i_state.saved_value;
                        end
                    end else if (w_st == ST_ARB_LOST) begin
                        o_state.phase = PH_START;
                        o_result.cmd  = CMD_START;
                    end else begin
                        o_state.phase = PH_IDLE;
                        o_result.cmd  = CMD_STOP;
                        o_result.done = 1'b1;
                    end
                end
                PH_RSTART: begin
                    if (w_st == ST_START || w_st == ST_REP_START) begin
                        o_state.phase    = PH_SLAR;
                        o_result.cmd     = CMD_BYTE;
                        o_result.tx_byte = {i_slave_address[7:1], 1'b1};
                    end else if (w_st == ST_ARB_LOST) begin
                        o_state.phase = PH_START;
                        o_result.cmd  = CMD_START;
                    end else begin
                        o_state.phase = PH_IDLE;
                        o_result.cmd  = CMD_STOP;
                        o_result.done = 1'b1;
                    end
                end
                PH_SLAR: begin
                    if (w_st == ST_MR_SLA_ACK && i_state.bytes_left != 8'd0) begin
                        o_state.phase = PH_RX;
                        o_result.cmd  = (i_state.bytes_left == 8'd1) ? CMD_RXNAK : CMD_RXACK;
                    end else if (w_st == ST_ARB_LOST) begin
                        o_state.phase = PH_START;
                        o_result.cmd  = CMD_START;
                    end else begin
                        o_state.phase = PH_IDLE;
                        o_result.cmd  = CMD_STOP;
                        o_result.done = 1'b1;
                    end
                end
                PH_RX: begin
                    if (w_st == ST_MR_DATA_ACK || w_st == ST_MR_DATA_NAK) begin
                        o_state.bytes_done  = w_bd_inc;
                        o_state.bytes_left  = w_bl_dec;
                        o_result.read_byte  = i_item.rx_byte;
                        o_result.read_valid = 1'b1;
                        if (w_st == ST_MR_DATA_NAK || w_bl_dec == 8'd0) begin
                            o_state.phase       = PH_IDLE;
                            o_result.cmd        = CMD_STOP;
                            o_result.done       = 1'b1;
                            o_result.byte_count = w_bd_inc;
                        end else begin
                            o_result.cmd = (w_bl_dec == 8'd1) ? CMD_RXNAK : CMD_RXACK;
                        end
                    end else begin
                        o_state.phase = PH_IDLE;
                        o_result.cmd  = CMD_STOP;
                        o_result.done = 1'b1;
                    end
                end
                PH_VAL: begin
                    o_state.phase       = PH_IDLE;
                    o_result.cmd        = CMD_STOP;
                    o_result.done       = 1'b1;
                    o_result.byte_count = {7'd0, (w_st == ST_MT_DATA_ACK)};
                end
                default: begin
                    o_state.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[src/i2c_master_register_transaction_unit.sv]
// i2c_master_register_transaction_unit: top level of the register transaction sequencer
// input register, i2cmrt_step logic, state and result register; depends on i2cmrt_pkg
//
// channel   handshake                 payload
// input     i_valid / o_ready         i_action i_reg_addr i_length i_write_value
//                                     i_bus_status i_rx_byte
// output    o_valid / i_ready         o_engine_command o_tx_byte o_read_byte
//                                     o_read_valid o_done_res o_byte_count
// config    i_cfg_we                  i_cfg_index i_cfg_data
//
// one item accepted per cycle unless the output stalls; each result passes through
// the input register, then the result register holding the new state
// synchronous active-low reset clears state, slave address to 0, attempts limit to 1600
// a stalled output holds the input register; o_ready drops only when both stages are full
`default_nettype none

module i2c_master_register_transaction_unit
    import i2cmrt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_reg_addr,
    input  wire logic [7:0]  i_length,
    input  wire logic [7:0]  i_write_value,
    input  wire logic [3:0]  i_bus_status,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_engine_command,
    output logic [7:0]       o_tx_byte,
    output logic [7:0]       o_read_byte,
    output logic             o_read_valid,
    output logic             o_done_res,
    output logic [7:0]       o_byte_count,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic        r_s1_valid;
    t_item       r_s1_item;
    logic        r_out_valid;
    t_result     r_res;
    t_state      r_state;
    logic [7:0]  r_slave_address;
    logic [15:0] r_max_attempts;

    t_state      n_state;
    t_result     n_res;
    logic        w_adv;

    assign w_adv   = !r_out_valid || i_ready;
    assign o_ready = !r_s1_valid || w_adv;

    i2cmrt_step u_step (
        .i_state         (r_state),
        .i_item          (r_s1_item),
        .i_slave_address (r_slave_address),
        .i_max_attempts  (r_max_attempts),
        .o_state         (n_state),
        .o_result        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_state         <= '{phase: PH_IDLE, default: '0};
            r_slave_address <= 8'd0;
            r_max_attempts  <= MAX_ATTEMPTS_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SLAVE_ADDRESS) begin
                    r_slave_address <= i_cfg_data[7:0];
                end else begin
                    r_max_attempts <= i_cfg_data;
                end
            end
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_item <= '{action: i_action, reg_addr: i_reg_addr, length: i_length,
                           write_value: i_write_value, bus_status: i_bus_status,
                           rx_byte: i_rx_byte};
        end
        if (w_adv && r_s1_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_engine_command = r_res.cmd;
    assign o_tx_byte        = r_res.tx_byte;
    assign o_read_byte      = r_res.read_byte;
    assign o_read_valid     = r_res.read_valid;
    assign o_done_res       = r_res.done;
    assign o_byte_count     = r_res.byte_count;

    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s1_valid && n_res.done) |=> (r_state.phase == PH_IDLE))
        else $error("phase not idle after transaction end");

    a_busy_has_attempt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != PH_IDLE) |-> (r_state.attempts_used != 16'd0))
        else $error("active transaction with no attempt counted");

    a_count_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_count != 8'd0) |-> o_done_res)
        else $error("byte count reported before the end");

    a_read_in_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s1_valid && n_res.read_valid) |-> (r_state.phase == PH_RX))
        else $error("byte delivered outside receive phase");

    a_state_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> $stable(r_state))
        else $error("state moved while output stalled");

endmodule

`default_nettype wire

[test/tb_i2c_master_register_transaction_unit.sv]
// tb_i2c_master_register_transaction_unit: self-checking bench for the register transaction sequencer
// predicts each engine reply from a local copy of the sequencing rules, checks it against the dut
// depends on i2cmrt_pkg and i2c_master_register_transaction_unit
module tb_i2c_master_register_transaction_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmrt_pkg::*;

    localparam logic [1:0] ACT_NONE     = 2'd3;
    localparam logic [3:0] ST_UNUSED    = 4'd15;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 3000;

    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_RHYTHM} t_sink_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [1:0]  i_action      = '0;
    logic [7:0]  i_reg_addr    = '0;
    logic [7:0]  i_length      = '0;
    logic [7:0]  i_write_value = '0;
    logic [3:0]  i_bus_status  = '0;
    logic [7:0]  i_rx_byte     = '0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [2:0]  o_engine_command;
    logic [7:0]  o_tx_byte;
    logic [7:0]  o_read_byte;
    logic        o_read_valid;
    logic        o_done_res;
    logic [7:0]  o_byte_count;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = 1'b0;
    logic [15:0] i_cfg_data    = '0;

    // sequencer copy
    logic [7:0]  cfg_slave        = 8'h00;
    logic [15:0] cfg_max_attempts = MAX_ATTEMPTS_RESET;
    t_phase      seq_phase        = PH_IDLE;
    logic        seq_is_read      = 1'b0;
    logic [15:0] seq_attempts     = '0;
    logic [7:0]  seq_left         = '0;
    logic [7:0]  seq_bytes_read   = '0;
    logic [7:0]  seq_reg          = '0;
    logic [7:0]  seq_value        = '0;

    t_result     pending_replies[$];
    int unsigned reply_errors     = 0;
    int unsigned useful_items     = 0;
    logic        rx_hold_req      = 1'b0;

    i2c_master_register_transaction_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_reg_addr       (i_reg_addr),
        .i_length         (i_length),
        .i_write_value    (i_write_value),
        .i_bus_status     (i_bus_status),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_engine_command (o_engine_command),
        .o_tx_byte        (o_tx_byte),
        .o_read_byte      (o_read_byte),
        .o_read_valid     (o_read_valid),
        .o_done_res       (o_done_res),
        .o_byte_count     (o_byte_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result select_attempt();
        t_result r;
        r = '0;
        if (seq_attempts >= cfg_max_attempts) begin
            seq_phase = PH_IDLE;
            r.done = 1'b1;
        end else begin
            seq_attempts = seq_attempts + 16'd1;
            seq_phase = PH_START;
            r.cmd = CMD_START;
        end
        return r;
    endfunction

    function automatic t_result restart_on_arbitration();
        t_result r;
        r = '0;
        seq_phase = PH_START;
        r.cmd = CMD_START;
        return r;
    endfunction

    function automatic t_result stop_reply(input logic [7:0] rb, input logic rv,
                                           input logic [7:0] cnt);
        t_result r;
        r = '0;
        seq_phase = PH_IDLE;
        r.cmd = CMD_STOP;
        r.read_byte = rb;
        r.read_valid = rv;
        r.done = 1'b1;
        r.byte_count = cnt;
        return r;
    endfunction

    function automatic t_result receive_reply(input logic [7:0] rb, input logic rv);
        t_result r;
        r = '0;
        seq_phase = PH_RX;
        r.cmd = (seq_left == 8'd1) ? CMD_RXNAK : CMD_RXACK;
        r.read_byte = rb;
        r.read_valid = rv;
        return r;
    endfunction

    function automatic t_result next_engine_reply(input t_item it);
        t_result    r;
        logic [3:0] status;
        r = '0;
        status = it.bus_status;
        if (it.action == ACT_READ || it.action == ACT_WRITE) begin
            if (seq_phase == PH_IDLE) begin
                seq_is_read = (it.action == ACT_READ);
                seq_reg = it.reg_addr;
                seq_left = it.length;
                seq_value = it.write_value;
                seq_bytes_read = '0;
                seq_attempts = '0;
                r = select_attempt();
            end
        end else if (it.action == ACT_EVENT) begin
            case (seq_phase)
                PH_START: begin
                    if (status == ST_START || status == ST_REP_START) begin
                        seq_phase = PH_SLAW;
                        r.cmd = CMD_BYTE;
                        r.tx_byte = cfg_slave & 8'hFE;
                    end else if (status == ST_ARB_LOST) begin
                        r = restart_on_arbitration();
                    end else begin
                        // failed start: give up without stop
                        seq_phase = PH_IDLE;
                        r.done = 1'b1;
                    end
                end
                PH_SLAW: begin
                    if (status == ST_MT_SLA_ACK) begin
                        seq_phase = PH_ADDR;
                        r.cmd = CMD_BYTE;
                        r.tx_byte = seq_reg;
                    end else if (status == ST_MT_SLA_NACK) begin
                        r = select_attempt();
                    end else if (status == ST_ARB_LOST) begin
                        r = restart_on_arbitration();
                    end else begin
                        r = stop_reply(8'h00, 1'b0, 8'h00);
                    end
                end
                PH_ADDR: begin
                    if (status == ST_MT_DATA_ACK) begin
                        if (seq_is_read) begin
                            seq_phase = PH_RSTART;
                            r.cmd = CMD_START;
                        end else begin
                            seq_phase = PH_VAL;
                            r.cmd = CMD_BYTE;
                            r.tx_byte = seq_value;
                        end
                    end else if (status == ST_ARB_LOST) begin
                        r = restart_on_arbitration();
                    end else begin
                        r = stop_reply(8'h00, 1'b0, 8'h00);
                    end
                end
                PH_RSTART: begin
                    if (status == ST_START || status == ST_REP_START) begin
                        seq_phase = PH_SLAR;
                        r.cmd = CMD_BYTE;
                        r.tx_byte = (cfg_slave & 8'hFE) | 8'h01;
                    end else if (status == ST_ARB_LOST) begin
                        r = restart_on_arbitration();
                    end else begin
                        r = stop_reply(8'h00, 1'b0, 8'h00);
                    end
                end
                PH_SLAR: begin
                    if (status == ST_MR_SLA_ACK) begin
                        if (seq_left == 8'd0) r = stop_reply(8'h00, 1'b0, 8'h00);
                        else r = receive_reply(8'h00, 1'b0);
                    end else if (status == ST_ARB_LOST) begin
                        r = restart_on_arbitration();
                    end else begin
                        r = stop_reply(8'h00, 1'b0, 8'h00);
                    end
                end
                PH_RX: begin
                    if (status == ST_MR_DATA_ACK || status == ST_MR_DATA_NAK) begin
                        // an early nack still delivers and counts its byte
                        seq_bytes_read = seq_bytes_read + 8'd1;
                        if (seq_left != 8'd0) seq_left = seq_left - 8'd1;
                        if (status == ST_MR_DATA_NAK || seq_left == 8'd0)
                            r = stop_reply(it.rx_byte, 1'b1, seq_bytes_read);
                        else
                            r = receive_reply(it.rx_byte, 1'b1);
                    end else begin
                        r = stop_reply(8'h00, 1'b0, 8'h00);
                    end
                end
                PH_VAL: begin
                    r = stop_reply(8'h00, 1'b0, (status == ST_MT_DATA_ACK) ? 8'd1 : 8'd0);
                end
                default: begin
                    seq_phase = PH_IDLE;
                end
            endcase
        end
        return r;
    endfunction

    function automatic logic [3:0] bus_reply(input logic [3:0] good, input int unsigned good_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < good_pct) return good;
        if (roll < good_pct + 4) return ST_ARB_LOST;
        return 4'($urandom);
    endfunction

    function automatic t_item next_bus_item();
        t_item      it;
        logic [3:0] good;
        it.action      = ACT_EVENT;
        it.reg_addr    = 8'($urandom);
        it.length      = 8'($urandom);
        it.write_value = 8'($urandom);
        it.bus_status  = 4'($urandom);
        it.rx_byte     = 8'($urandom);
        // noise: anything at all
        if ($urandom_range(0, 99) < 8) begin
            it.action = 2'($urandom);
            return it;
        end
        case (seq_phase)
            PH_IDLE: begin
                it.action = ($urandom_range(0, 9) < 6) ? ACT_READ : ACT_WRITE;
                good = 4'($urandom_range(0, 99));
                if ($urandom_range(0, 99) < 3) it.length = 8'($urandom_range(200, 255));
                else if ($urandom_range(0, 99) < 12) it.length = 8'($urandom_range(5, 20));
                else it.length = 8'($urandom_range(0, 4));
            end
            PH_START, PH_RSTART: begin
                good = $urandom_range(0, 1) ? ST_REP_START : ST_START;
                it.bus_status = bus_reply(good, 90);
            end
            PH_SLAW: begin
                if ($urandom_range(0, 99) < 15) it.bus_status = ST_MT_SLA_NACK;
                else it.bus_status = bus_reply(ST_MT_SLA_ACK, 88);
            end
            PH_ADDR, PH_VAL: it.bus_status = bus_reply(ST_MT_DATA_ACK, 90);
            PH_SLAR: it.bus_status = bus_reply(ST_MR_SLA_ACK, 90);
            default: begin
                if (seq_left == 8'd1 || $urandom_range(0, 39) == 0) good = ST_MR_DATA_NAK;
                else good = ST_MR_DATA_ACK;
                it.bus_status = bus_reply(good, 95);
            end
        endcase
        return it;
    endfunction

    function automatic t_item command_item(input logic [1:0] action, input logic [7:0] reg_addr,
                                           input logic [7:0] length, input logic [7:0] value);
        t_item it;
        it = '0;
        it.action = action;
        it.reg_addr = reg_addr;
        it.length = length;
        it.write_value = value;
        return it;
    endfunction

    function automatic t_item event_item(input logic [3:0] status, input logic [7:0] rx);
        t_item it;
        it = '0;
        it.action = ACT_EVENT;
        it.bus_status = status;
        it.rx_byte = rx;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        reply_errors++;
        if (reply_errors <= 30)
            $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic send_item(input t_item it);
        bit ignored;
        i_valid       <= 1'b1;
        i_action      <= it.action;
        i_reg_addr    <= it.reg_addr;
        i_length      <= it.length;
        i_write_value <= it.write_value;
        i_bus_status  <= it.bus_status;
        i_rx_byte     <= it.rx_byte;
        do @(posedge i_clk); while (!o_ready);
        ignored = (it.action == ACT_NONE)
                || (it.action == ACT_EVENT && seq_phase == PH_IDLE)
                || (it.action != ACT_EVENT && seq_phase != PH_IDLE);
        if (!ignored) useful_items++;
        pending_replies.push_back(next_engine_reply(it));
    endtask

    task automatic pause_sender(input int unsigned cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // sender idles until every reply is back
    task automatic settle_block();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (index == CFG_SLAVE_ADDRESS) cfg_slave = data[7:0];
        else cfg_max_attempts = data;
    endtask

    task automatic test_register_read();
        write_register(CFG_SLAVE_ADDRESS, 16'h00A4);
        send_item(command_item(ACT_READ, 8'hFF, 8'd2, 8'h00));
        send_item(event_item(ST_START, 8'h00));
        send_item(event_item(ST_MT_SLA_ACK, 8'h00));
        send_item(event_item(ST_MT_DATA_ACK, 8'h00));
        send_item(event_item(ST_REP_START, 8'h00));
        send_item(event_item(ST_MR_SLA_ACK, 8'h00));
        send_item(event_item(ST_MR_DATA_ACK, 8'h00));
        send_item(event_item(ST_MR_DATA_NAK, 8'hFF));
    endtask

    // value nacked by the slave
    task automatic test_register_write();
        send_item(command_item(ACT_WRITE, 8'h00, 8'hFF, 8'hFF));
        send_item(event_item(ST_START, 8'hFF));
        send_item(event_item(ST_MT_SLA_ACK, 8'h00));
        send_item(event_item(ST_MT_DATA_ACK, 8'h00));
        send_item(event_item(ST_MT_DATA_NAK, 8'h00));
    endtask

    task automatic test_zero_attempts();
        settle_block();
        write_register(CFG_MAX_ATTEMPTS, 16'd0);
        send_item(command_item(ACT_WRITE, 8'h5A, 8'h00, 8'hA5));
        settle_block();
        write_register(CFG_MAX_ATTEMPTS, 16'd2);
    endtask

    // arbitration loss restarts freely, second selection nack gives up
    task automatic test_selection_retry();
        send_item(command_item(ACT_READ, 8'h12, 8'd1, 8'h00));
        send_item(event_item(ST_ARB_LOST, 8'h00));
        send_item(event_item(ST_START, 8'h00));
        send_item(event_item(ST_MT_SLA_NACK, 8'h00));
        send_item(event_item(ST_REP_START, 8'h00));
        send_item(event_item(ST_MT_SLA_NACK, 8'h00));
    endtask

    task automatic test_ignored_items();
        send_item(event_item(ST_START, 8'h3C));
        send_item(command_item(ACT_NONE, 8'hFF, 8'hFF, 8'hFF));
        send_item(command_item(ACT_WRITE, 8'h01, 8'h00, 8'h80));
        send_item(command_item(ACT_READ, 8'h02, 8'h03, 8'h00));
        send_item(event_item(ST_UNUSED, 8'h00));
    endtask

    task automatic test_output_hold_off();
        rx_hold_req <= 1'b1;
        repeat (40) send_item(next_bus_item());
        settle_block();
    endtask

    task automatic test_sender_pause();
        repeat (3) begin
            repeat ($urandom_range(4, 12)) send_item(next_bus_item());
            i_valid <= 1'b0;
            while (pending_replies.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic traffic_phase(input logic [15:0] slave_data, input logic [15:0] limit_data,
                                 input int unsigned count);
        int unsigned target;
        settle_block();
        write_register(CFG_SLAVE_ADDRESS, slave_data);
        write_register(CFG_MAX_ATTEMPTS, limit_data);
        target = useful_items + count;
        while (useful_items < target) begin
            repeat ($urandom_range(1, 32)) send_item(next_bus_item());
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
        end
    endtask

    task automatic test_config_sweep();
        traffic_phase(16'hFFFF, 16'hFFFF, 200);
        traffic_phase(16'($urandom), 16'd1, 200);
        traffic_phase(16'h0000, 16'd3, 200);
        traffic_phase(16'($urandom), MAX_ATTEMPTS_RESET, 200);
        traffic_phase(16'($urandom), 16'($urandom_range(1, 6)), 200);
    endtask

    initial begin : reply_sink
        t_sink_mode  sink_mode;
        int unsigned mode_left;
        int unsigned tick;
        bit          hold_taken;
        sink_mode = SINK_OPEN;
        mode_left = 0;
        tick = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            tick++;
            case (sink_mode)
                SINK_OPEN:   i_ready <= 1'b1;
                SINK_RANDOM: i_ready <= 1'($urandom_range(0, 1));
                default:     i_ready <= (tick % 3 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : reply_check
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got.cmd        = t_cmd'(o_engine_command);
            got.tx_byte    = o_tx_byte;
            got.read_byte  = o_read_byte;
            got.read_valid = o_read_valid;
            got.done       = o_done_res;
            got.byte_count = o_byte_count;
            if (pending_replies.size() == 0) begin
                report_mismatch("reply with none pending, engine_command", got.cmd, 0);
            end else begin
                want = pending_replies.pop_front();
                if (got.cmd !== want.cmd)
                    report_mismatch("engine_command", got.cmd, want.cmd);
                if (got.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
                if (got.read_byte !== want.read_byte)
                    report_mismatch("read_byte", got.read_byte, want.read_byte);
                if (got.read_valid !== want.read_valid)
                    report_mismatch("read_valid", got.read_valid, want.read_valid);
                if (got.done !== want.done)
                    report_mismatch("done_res", got.done, want.done);
                if (got.byte_count !== want.byte_count)
                    report_mismatch("byte_count", got.byte_count, want.byte_count);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("** i2c_master_register_transaction_unit: FAILED **");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_read();
        test_register_write();
        test_zero_attempts();
        test_selection_retry();
        test_ignored_items();
        test_output_hold_off();
        test_sender_pause();
        test_config_sweep();
        settle_block();
        if (reply_errors == 0) begin
            $display("** i2c_master_register_transaction_unit: PASSED **");
        end else begin
            $display("** i2c_master_register_transaction_unit: FAILED **");
        end
        $finish;
    end

endmodule
